>>> design/jkv_pkg.sv
// Shared types and constants for the JSON key/value extractor.
package jkv_pkg;

   localparam int RUN_CNT_W       = 6;
   localparam int CSR_INDEX_W     = 2;
   localparam int CMD_QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH   = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DISCARD  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [1:0] BLANK_SPACE = 2'd0;
   localparam logic [1:0] BLANK_TAB   = 2'd1;
   localparam logic [1:0] BLANK_CR    = 2'd2;

   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   typedef struct packed {
      logic                 has_byte;
      logic [7:0]           value_byte;
      logic [RUN_CNT_W-1:0] flush_cnt;
      logic                 blank_wr;
      logic [RUN_CNT_W-1:0] blank_idx;
      logic [1:0]           blank_code;
      logic                 has_last;
      logic [1:0]           status;
   } cmd_type;

   function automatic logic [7:0] blank_char(input logic [1:0] code);
      logic [7:0] ch;
      case (code)
         BLANK_SPACE: ch = CH_SPACE;
         BLANK_TAB:   ch = CH_TAB;
         default:     ch = CH_CR;
      endcase
      return ch;
   endfunction

endpackage

>>> design/json_key_value_extractor.sv
// Path: a byte's command is written into the command queue, and each result into the result register.
// Throughput: one byte per cycle in while the queue is not full; the back end delivers one result
// a cycle while the receiver pops, so a byte that releases n held blanks plus itself gives n + 1 results.
// The 4-entry command queue absorbs such bursts before push is refused.
// Reset: synchronous, active high; clears phase, counters, queue and key registers.
// Top level of the JSON key/value extractor.
module json_key_value_extractor #(
   parameter int KEY_MAX       = 16,
   parameter int BLANK_RUN_MAX = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_end_of_document,
   output logic                             empty,
   input  logic                             pop,
   output logic [7:0]                       rsp_value_byte,
   output logic                             rsp_byte_valid,
   output logic                             rsp_last,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jkv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                      csr_data
);
   import jkv_pkg::*;

   cmd_type cmd, head;
   logic    cmd_push, head_valid, head_pop, in_accept;

   assign csr_ready = 1'b1;
   assign in_accept = push && !full;

   jkv_front #(
      .KEY_MAX       (KEY_MAX),
      .BLANK_RUN_MAX (BLANK_RUN_MAX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (in_accept),
      .data_byte       (req_data_byte),
      .end_of_document (req_end_of_document),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   jkv_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd),
      .pop        (head_pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   jkv_back #(
      .BLANK_RUN_MAX (BLANK_RUN_MAX)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .head_pop       (head_pop),
      .rsp_pop        (pop),
      .rsp_empty      (empty),
      .rsp_value_byte (rsp_value_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

>>> design/jkv_front.sv
// Front end: key window match, phase tracking and command generation per byte.
module jkv_front #(
   parameter int KEY_MAX       = 16,
   parameter int BLANK_RUN_MAX = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_accept,
   input  logic [7:0]                       data_byte,
   input  logic                             end_of_document,
   input  logic                             csr_write,
   input  logic [jkv_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                      csr_data,
   output logic                             cmd_push,
   output jkv_pkg::cmd_type                 cmd
);
   import jkv_pkg::*;

   localparam int WIN_LEN   = KEY_MAX + 2;
   localparam int FILL_W    = $clog2(WIN_LEN + 1);
   localparam int LEN_W     = $clog2(KEY_MAX + 1);
   localparam int WIN_IDX_W = $clog2(WIN_LEN);

   typedef enum logic [5:0] {
      PH_MATCH  = 6'b000001,
      PH_COLON  = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_QUOTED = 6'b001000,
      PH_BARE   = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [7:0]           win_ff [WIN_LEN];
   logic [7:0]           win_in [WIN_LEN];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [7:0]           prev_ff;
   logic [RUN_CNT_W-1:0] blank_cnt_ff, blank_cnt_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 overflow_ff, overflow_in;
   logic [4:0]           key_length_ff;
   logic [63:0]          key_low_ff, key_high_ff;

   logic [127:0]         key_all;
   logic [LEN_W-1:0]     key_len_c;
   logic [FILL_W-1:0]    total_c;
   logic [WIN_IDX_W:0]   base_c;
   logic [WIN_IDX_W:0]   pos_c;
   logic                 match_c;
   logic                 is_blank, is_term, is_skip;
   logic [1:0]           code_c;

   assign key_all = {key_high_ff, key_low_ff};
   assign key_len_c = (key_length_ff > 5'(KEY_MAX)) ? LEN_W'(KEY_MAX)
                                                   : key_length_ff[LEN_W-1:0];

   always_comb begin
      for (int k = 0; k < WIN_LEN - 1; k++) begin
         win_in[k] = win_ff[k+1];
      end
      win_in[WIN_LEN-1] = data_byte;
      fill_in = (fill_ff == FILL_W'(WIN_LEN)) ? fill_ff : fill_ff + FILL_W'(1);
   end

   // compare the shifted window against quote, key, quote
   always_comb begin
      total_c = FILL_W'(key_len_c) + FILL_W'(2);
      base_c  = (WIN_IDX_W+1)'(WIN_LEN) - (WIN_IDX_W+1)'(total_c);
      match_c = (fill_in >= total_c) && (win_in[WIN_LEN-1] == CH_QUOTE)
                && (win_in[base_c[WIN_IDX_W-1:0]] == CH_QUOTE);
      pos_c = '0;
      for (int i = 0; i < KEY_MAX; i++) begin
         pos_c = base_c + (WIN_IDX_W+1)'(i + 1);
         if ((LEN_W+1)'(i) < (LEN_W+1)'(key_len_c)) begin
            if (win_in[pos_c[WIN_IDX_W-1:0]] != key_all[8*i +: 8]) begin
               match_c = 1'b0;
            end
         end
      end
   end

   assign is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) || (data_byte == CH_CR);
   assign is_skip  = (data_byte == CH_SPACE) || (data_byte == CH_TAB)
                     || (data_byte == CH_NEWLINE);
   assign is_term  = (data_byte == CH_COMMA) || (data_byte == CH_RBRACE)
                     || (data_byte == CH_NEWLINE) || (data_byte == CH_RBRACKET);
   assign code_c   = (data_byte == CH_SPACE) ? BLANK_SPACE
                   : ((data_byte == CH_TAB) ? BLANK_TAB : BLANK_CR);

   always_comb begin
      logic bare;
      bare         = 1'b0;
      phase_in     = phase_ff;
      blank_cnt_in = blank_cnt_ff;
      nonempty_in  = nonempty_ff;
      overflow_in  = overflow_ff;
      cmd          = '0;
      case (phase_ff)
         PH_MATCH: begin
            if (match_c) begin
               phase_in = PH_COLON;
            end
         end
         PH_COLON: begin
            if (data_byte == CH_COLON) begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (!is_skip) begin
               if (data_byte == CH_QUOTE) begin
                  phase_in = PH_QUOTED;
               end else begin
                  phase_in = PH_BARE;
                  bare     = 1'b1;
               end
            end
         end
         PH_QUOTED: begin
            if ((data_byte == CH_QUOTE) && (prev_ff != CH_BACKSLASH)) begin
               phase_in = PH_DONE;
            end else begin
               cmd.has_byte   = 1'b1;
               cmd.value_byte = data_byte;
               nonempty_in    = 1'b1;
            end
         end
         PH_BARE: begin
            bare = 1'b1;
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (bare) begin
         if (is_term) begin
            blank_cnt_in = '0;
            phase_in     = PH_DONE;
         end else if (is_blank) begin
            if (nonempty_ff) begin
               if (blank_cnt_ff < RUN_CNT_W'(BLANK_RUN_MAX)) begin
                  cmd.blank_wr   = 1'b1;
                  cmd.blank_idx  = blank_cnt_ff;
                  cmd.blank_code = code_c;
                  blank_cnt_in   = blank_cnt_ff + RUN_CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
         end else if (!end_of_document) begin
            cmd.has_byte   = 1'b1;
            cmd.value_byte = data_byte;
            cmd.flush_cnt  = blank_cnt_ff;
            blank_cnt_in   = '0;
            nonempty_in    = 1'b1;
         end
      end

      if (end_of_document) begin
         cmd.has_last = 1'b1;
         if ((phase_in != PH_DONE) || !nonempty_in) begin
            cmd.status = STATUS_DISCARD;
         end else if (overflow_in) begin
            cmd.status = STATUS_OVERFLOW;
         end else begin
            cmd.status = STATUS_OK;
         end
         phase_in     = PH_MATCH;
         blank_cnt_in = '0;
         nonempty_in  = 1'b0;
         overflow_in  = 1'b0;
      end
   end

   assign cmd_push = in_accept && (cmd.has_byte || cmd.has_last || cmd.blank_wr);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MATCH;
         fill_ff       <= '0;
         prev_ff       <= '0;
         blank_cnt_ff  <= '0;
         nonempty_ff   <= 1'b0;
         overflow_ff   <= 1'b0;
         key_length_ff <= '0;
         key_low_ff    <= '0;
         key_high_ff   <= '0;
      end else begin
         if (in_accept) begin
            phase_ff     <= phase_in;
            prev_ff      <= end_of_document ? 8'd0 : data_byte;
            blank_cnt_ff <= blank_cnt_in;
            nonempty_ff  <= nonempty_in;
            overflow_ff  <= overflow_in;
            if (end_of_document) begin
               fill_ff <= '0;
            end else if (phase_ff == PH_MATCH) begin
               fill_ff <= fill_in;
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_LENGTH: key_length_ff <= csr_data[4:0];
               CSR_KEY_LOW:    key_low_ff    <= csr_data;
               CSR_KEY_HIGH:   key_high_ff   <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && (phase_ff == PH_MATCH)) begin
         win_ff <= win_in;
      end
   end

endmodule

>>> design/jkv_cmd_queue.sv
// Short command queue between the front and back ends.
module jkv_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jkv_pkg::cmd_type push_data,
   input  logic             pop,
   output jkv_pkg::cmd_type head,
   output logic             head_valid,
   output logic             full
);
   import jkv_pkg::*;

   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type          entry_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(CMD_QUEUE_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/jkv_back.sv
// Back end: held blank store, command expansion and the result register.
module jkv_back #(
   parameter int BLANK_RUN_MAX = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  jkv_pkg::cmd_type head,
   input  logic             head_valid,
   output logic             head_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [7:0]       rsp_value_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   output logic [1:0]       rsp_status
);
   import jkv_pkg::*;

   localparam int IDX_W     = (BLANK_RUN_MAX > 1) ? $clog2(BLANK_RUN_MAX) : 1;
   localparam int MEM_DEPTH = 1 << IDX_W;

   logic [1:0]           blank_mem_ff [MEM_DEPTH];
   logic [RUN_CNT_W-1:0] flush_idx_ff, flush_idx_in;
   logic                 byte_done_ff, byte_done_in;
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_bvalid_ff, out_bvalid_in;
   logic                 out_last_ff, out_last_in;
   logic [1:0]           out_status_ff, out_status_in;
   logic                 out_free, emit;

   assign out_free = !out_valid_ff || rsp_pop;

   always_comb begin
      head_pop      = 1'b0;
      emit          = 1'b0;
      flush_idx_in  = flush_idx_ff;
      byte_done_in  = byte_done_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      if (head_valid) begin
         if (flush_idx_ff < head.flush_cnt) begin
            if (out_free) begin
               emit          = 1'b1;
               out_byte_in   = blank_char(blank_mem_ff[flush_idx_ff[IDX_W-1:0]]);
               out_bvalid_in = 1'b1;
               out_last_in   = 1'b0;
               out_status_in = STATUS_OK;
               flush_idx_in  = flush_idx_ff + RUN_CNT_W'(1);
            end
         end else if (head.has_byte && !byte_done_ff) begin
            if (out_free) begin
               emit          = 1'b1;
               out_byte_in   = head.value_byte;
               out_bvalid_in = 1'b1;
               out_last_in   = 1'b0;
               out_status_in = STATUS_OK;
               byte_done_in  = 1'b1;
               head_pop      = !head.has_last;
            end
         end else if (head.has_last) begin
            if (out_free) begin
               emit          = 1'b1;
               out_byte_in   = 8'd0;
               out_bvalid_in = 1'b0;
               out_last_in   = 1'b1;
               out_status_in = head.status;
               head_pop      = 1'b1;
            end
         end else begin
            head_pop = 1'b1;
         end
      end
      if (head_pop) begin
         flush_idx_in = '0;
         byte_done_in = 1'b0;
      end
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_idx_ff <= '0;
         byte_done_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         flush_idx_ff <= flush_idx_in;
         byte_done_ff <= byte_done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      if (head_pop && head.blank_wr) begin
         blank_mem_ff[head.blank_idx[IDX_W-1:0]] <= head.blank_code;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_value_byte = out_byte_ff;
   assign rsp_byte_valid = out_bvalid_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_status     = out_status_ff;

endmodule

>>> tb/jkv_lookup_checker.sv
// Checker for the JSON key/value extractor: predicts the value stream and compares every result.
`timescale 1ns / 1ps
module jkv_lookup_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            full,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_end_of_document,
   input  logic                            empty,
   input  logic                            pop,
   input  logic [7:0]                      rsp_value_byte,
   input  logic                            rsp_byte_valid,
   input  logic                            rsp_last,
   input  logic [1:0]                      rsp_status,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [jkv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_data,
   output int                              fail_count,
   output int                              pending
);
   import jkv_pkg::*;

   localparam int KEY_CHARS  = 16;
   localparam int WINDOW_LEN = KEY_CHARS + 2;
   localparam int RUN_MAX    = 16;

   typedef enum logic [2:0] {
      SEEK_KEY, SEEK_COLON, SKIP_BLANKS, IN_QUOTED, IN_BARE, VALUE_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       last;
      logic [1:0] status;
   } value_item_type;

   logic [4:0]  key_len_reg;
   logic [63:0] key_lo_reg;
   logic [63:0] key_hi_reg;

   scan_phase_type phase;
   logic [7:0]     window [WINDOW_LEN];
   int             window_fill;
   logic [7:0]     prev_byte;
   int             held_count;
   logic [7:0]     held_blanks [RUN_MAX];
   bit             seen_value;
   bit             run_overflow;

   value_item_type expected_values [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [7:0] key_byte(int i);
      return i < 8 ? key_lo_reg[i*8 +: 8] : key_hi_reg[(i-8)*8 +: 8];
   endfunction

   function automatic bit key_in_window();
      int len;
      int base;
      bit hit;
      len = key_len_reg > KEY_CHARS ? KEY_CHARS : int'(key_len_reg);
      if (window_fill < len + 2) return 1'b0;
      base = WINDOW_LEN - len - 2;
      hit  = window[base] == CH_QUOTE && window[WINDOW_LEN-1] == CH_QUOTE;
      for (int i = 0; i < len; i++)
         if (window[base+1+i] != key_byte(i)) hit = 1'b0;
      return hit;
   endfunction

   task automatic start_document();
      phase        = SEEK_KEY;
      window_fill  = 0;
      prev_byte    = 8'h00;
      held_count   = 0;
      seen_value   = 1'b0;
      run_overflow = 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) window[i] = 8'h00;
   endtask

   task automatic add_expected(logic [7:0] b, logic valid, logic is_last, logic [1:0] st);
      value_item_type item;
      item = '{value_byte: b, byte_valid: valid, last: is_last, status: st};
      expected_values = {expected_values, item};
   endtask

   task automatic bare_value_byte(logic [7:0] b, logic eod);
      if (b == CH_COMMA || b == CH_RBRACE || b == CH_NEWLINE || b == CH_RBRACKET) begin
         held_count = 0;
         phase      = VALUE_DONE;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
         if (seen_value) begin
            if (held_count < RUN_MAX) begin
               held_blanks[held_count] = b;
               held_count++;
            end else begin
               run_overflow = 1'b1;
            end
         end
      end else if (!eod) begin
         for (int i = 0; i < held_count; i++)
            add_expected(held_blanks[i], 1'b1, 1'b0, STATUS_OK);
         held_count = 0;
         add_expected(b, 1'b1, 1'b0, STATUS_OK);
         seen_value = 1'b1;
      end
   endtask

   task automatic predict_byte(logic [7:0] b, logic eod);
      logic [1:0] st;
      case (phase)
         SEEK_KEY: begin
            for (int i = 0; i < WINDOW_LEN - 1; i++) window[i] = window[i+1];
            window[WINDOW_LEN-1] = b;
            if (window_fill < WINDOW_LEN) window_fill++;
            if (key_in_window()) phase = SEEK_COLON;
         end
         SEEK_COLON: begin
            if (b == CH_COLON) phase = SKIP_BLANKS;
         end
         SKIP_BLANKS: begin
            if (!(b == CH_SPACE || b == CH_TAB || b == CH_NEWLINE)) begin
               if (b == CH_QUOTE) begin
                  phase = IN_QUOTED;
               end else begin
                  phase = IN_BARE;
                  bare_value_byte(b, eod);
               end
            end
         end
         IN_QUOTED: begin
            if (b == CH_QUOTE && prev_byte != CH_BACKSLASH) begin
               phase = VALUE_DONE;
            end else begin
               add_expected(b, 1'b1, 1'b0, STATUS_OK);
               seen_value = 1'b1;
            end
         end
         IN_BARE: bare_value_byte(b, eod);
         default: ;
      endcase
      prev_byte = b;
      if (eod) begin
         if (phase != VALUE_DONE || !seen_value) st = STATUS_DISCARD;
         else if (run_overflow)                  st = STATUS_OVERFLOW;
         else                                    st = STATUS_OK;
         add_expected(8'h00, 1'b0, 1'b1, st);
         start_document();
      end
   endtask

   always @(posedge clock) begin
      value_item_type got;
      value_item_type want;
      if (reset) begin
         key_len_reg = '0;
         key_lo_reg  = '0;
         key_hi_reg  = '0;
         start_document();
         expected_values.delete();
         pending = 0;
      end else begin
         if (pop && !empty) begin
            got = {rsp_value_byte, rsp_byte_valid, rsp_last, rsp_status};
            if (expected_values.size() == 0) begin
               $display("%0t: unexpected result, expected none", $time);
               $display("%0t:   actual byte=%h valid=%b last=%b status=%0d",
                        $time, got.value_byte, got.byte_valid, got.last, got.status);
               fail_count++;
            end else begin
               want = expected_values.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch, expected byte=%h valid=%b last=%b status=%0d",
                           $time, want.value_byte, want.byte_valid, want.last, want.status);
                  $display("%0t:                   actual byte=%h valid=%b last=%b status=%0d",
                           $time, got.value_byte, got.byte_valid, got.last, got.status);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_LENGTH: key_len_reg = csr_data[4:0];
               CSR_KEY_LOW:    key_lo_reg  = csr_data;
               CSR_KEY_HIGH:   key_hi_reg  = csr_data;
               default: ;
            endcase
         end
         if (push && !full) predict_byte(req_data_byte, req_end_of_document);
         pending = expected_values.size();
      end
   end

endmodule

>>> tb/tb.sv
// Top of the JSON key/value extractor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
   import jkv_pkg::*;

   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int PHASE_ITEMS    = 62;

   typedef logic [7:0] byte_queue_type [$];

   logic                   clock;
   logic                   reset               = 1'b1;
   logic                   push                = 1'b0;
   logic                   full;
   logic [7:0]             req_data_byte       = 8'h00;
   logic                   req_end_of_document = 1'b0;
   logic                   empty;
   logic                   pop                 = 1'b0;
   logic [7:0]             rsp_value_byte;
   logic                   rsp_byte_valid;
   logic                   rsp_last;
   logic [1:0]             rsp_status;
   logic                   csr_valid           = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index           = CSR_KEY_LENGTH;
   logic [63:0]            csr_data            = 64'd0;
   int                     fail_count;
   int                     pending;

   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          items_sent         = 0;
   int          quiet_cycles       = 0;
   logic [4:0]  cur_len            = '0;
   logic [63:0] cur_lo             = '0;
   logic [63:0] cur_hi             = '0;

   json_key_value_extractor uut (.*);
   jkv_lookup_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) pop <= ($urandom_range(0, 99) >= receiver_stall_pct);

   // nothing transferred for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic eod);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push                <= 1'b1;
      req_data_byte       <= b;
      req_end_of_document <= eod;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   task automatic send_doc(byte_queue_type d);
      foreach (d[i]) send_byte(d[i], i == d.size() - 1);
   endtask

   task automatic send_text(string s);
      byte_queue_type d;
      for (int i = 0; i < s.len(); i++) d = {d, s[i]};
      send_doc(d);
   endtask

   task automatic drain_results();
      @(negedge clock);
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_key(logic [4:0] len, logic [63:0] lo, logic [63:0] hi);
      write_csr(CSR_KEY_LENGTH, 64'(len));
      write_csr(CSR_KEY_LOW, lo);
      write_csr(CSR_KEY_HIGH, hi);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_len = len;
      cur_lo  = lo;
      cur_hi  = hi;
   endtask

   function automatic logic [63:0] random_key_word(bit printable);
      logic [63:0] w;
      for (int i = 0; i < 8; i++)
         w[i*8 +: 8] = printable ? 8'($urandom_range(8'h61, 8'h7A))
                                 : 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic logic [7:0] one_of(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                         logic [7:0] d);
      case ($urandom_range(0, 3))
         0:       return a;
         1:       return b;
         2:       return c;
         default: return d;
      endcase
   endfunction

   function automatic logic [7:0] value_char();
      return $urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   // mostly well-formed documents with random content; some broken or truncated
   function automatic byte_queue_type random_doc();
      byte_queue_type d;
      int             klen;
      int             roll;
      int             run;
      int             cut;
      klen = cur_len > 16 ? 16 : int'(cur_len);
      repeat ($urandom_range(0, 3)) d = {d, 8'($urandom_range(0, 255))};
      roll = $urandom_range(0, 99);
      if (roll < 8) d = {d, CH_COLON};
      if (roll < 88) begin
         d = {d, CH_QUOTE};
         for (int i = 0; i < klen; i++)
            d = {d, i < 8 ? cur_lo[i*8 +: 8] : cur_hi[(i-8)*8 +: 8]};
         d = {d, CH_QUOTE};
      end else if (roll < 94) begin
         d = {d, CH_QUOTE};
         for (int i = 0; i < klen / 2; i++) d = {d, cur_lo[i*8 +: 8]};
      end
      repeat ($urandom_range(0, 2)) d = {d, one_of(CH_SPACE, "x", CH_COMMA, CH_QUOTE)};
      if ($urandom_range(0, 9) != 0) d = {d, CH_COLON};
      repeat ($urandom_range(0, 3)) d = {d, one_of(CH_SPACE, CH_TAB, CH_NEWLINE, CH_SPACE)};
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         d = {d, CH_QUOTE};
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 5) == 0) begin
               if ($urandom_range(0, 1) == 0) d = {d, CH_BACKSLASH};
               d = {d, CH_BACKSLASH};
               d = {d, CH_QUOTE};
            end else begin
               d = {d, value_char()};
            end
         end
         if ($urandom_range(0, 9) != 0) d = {d, CH_QUOTE};
      end else if (roll < 92) begin
         repeat ($urandom_range(0, 2)) d = {d, one_of(CH_SPACE, CH_TAB, CH_CR, CH_SPACE)};
         repeat ($urandom_range(0, 4)) begin
            d = {d, value_char()};
            run = $urandom_range(0, 9) == 0 ? $urandom_range(14, 19) : $urandom_range(0, 3);
            repeat (run) d = {d, one_of(CH_SPACE, CH_TAB, CH_CR, CH_SPACE)};
         end
         if ($urandom_range(0, 9) != 0)
            d = {d, one_of(CH_COMMA, CH_RBRACE, CH_NEWLINE, CH_RBRACKET)};
      end
      repeat ($urandom_range(0, 3)) d = {d, 8'($urandom_range(0, 255))};
      if (d.size() == 0) d = {d, 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(0, d.size() - 1);
         d   = d[0:cut];
      end
      return d;
   endfunction

   initial begin
      int target;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // key "k": escaped quote, bare value with held blanks, bare byte cut by end of document
      program_key(5'd1, 64'h6B, 64'd0);
      send_text("\"k\":\"a\\\"b\"");
      send_text("\"k\": x \ty \015}");
      send_text("\"k\":z");

      for (int p = 0; p < 6; p++) begin
         drain_results();
         case (p)
            0:       program_key(5'd3, random_key_word(1'b1), 64'd0);
            1:       program_key(5'd16, '1, '1);
            2:       program_key(5'd0, '0, '0);
            3:       program_key(5'd31, random_key_word(1'b1), random_key_word(1'b1));
            4:       program_key(5'($urandom_range(1, 15)), random_key_word(1'b0),
                                 random_key_word(1'b0));
            default: program_key(5'd8, random_key_word(1'b1), random_key_word(1'b0));
         endcase
         case (p % 4)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            send_doc(random_doc());
            if ($urandom_range(0, 7) == 0) drain_results();
         end
      end

      drain_results();
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
